// ----- design/mds_pkg.sv -----
// shared types and constants for the multibyte delimiter splitter
package mds_pkg;

    // window and delimiter geometry
    localparam int DELIM_MAX   = 8;
    localparam int WIN_DEPTH   = 8;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int WIN_CNT_W   = $clog2(WIN_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int DELIM_W     = DELIM_MAX * BYTE_W;
    localparam int DLEN_W      = 4;

    // output queue geometry
    localparam int OQ_DEPTH    = 2;
    localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W    = $clog2(OQ_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'b1;

    // reset values of the registers
    localparam logic [DELIM_W-1:0] DELIM_BYTES_RST  = DELIM_W'(44);
    localparam logic [DLEN_W-1:0]  DELIM_LENGTH_RST = DLEN_W'(1);

    // input word
    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [BYTE_W-1:0] token_byte;
        logic              token_end;
        logic              run_last;
    } t_out_word;

    // how the window moves in one cycle
    typedef enum logic [1:0] {
        SH_HOLD,
        SH_ONE,
        SH_LEN
    } t_shift;

    // control handed to each window cell
    typedef struct packed {
        logic   append;
        logic   active;
        t_shift shift;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_FLUSH,
        ST_CLOSE
    } t_state;

endpackage

// ----- design/multibyte_delimiter_splitter_core.sv -----
// splitter top level: window cell row, sequencer, config registers, output queue
// Throughput: one byte word per cycle while each word gives at most one result and the
// output queue is not full. A word with end_of_string then holds the input while the
// bytes left in the window are flushed and the closing marker for an open token is sent.
// Each result is registered in the output queue before it reaches the output.
// Reset (synchronous, active low): window empty, no token open, delimiter ',' of length 1.
module multibyte_delimiter_splitter_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  mds_pkg::t_in_word                     i_in_data,
    output logic                                  o_in_stall,
    output logic                                  o_out_valid,
    output mds_pkg::t_out_word                    o_out_data,
    input  logic                                  i_out_stall,
    input  logic                                  i_cfg_we,
    input  logic [mds_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mds_pkg::DELIM_W-1:0]           i_cfg_data
);

    logic [mds_pkg::DELIM_W-1:0]    r_delim;
    logic [mds_pkg::DLEN_W-1:0]     r_dlen;
    logic [mds_pkg::WIN_CNT_W-1:0]  r_count;
    logic [mds_pkg::WIN_CNT_W-1:0]  n_count;
    logic                           r_open;
    logic                           n_open;
    mds_pkg::t_state                r_state;
    mds_pkg::t_state                n_state;

    logic [mds_pkg::WIN_CNT_W-1:0]  len_eff;
    logic [mds_pkg::WIN_CNT_W-1:0]  cnt_a;
    logic [mds_pkg::WIN_CNT_W-1:0]  cnt_left;
    logic                           open_left;
    logic                           in_take;
    logic                           append;
    mds_pkg::t_shift                shift;
    logic                           push;
    mds_pkg::t_out_word             push_word;
    logic                           q_full;
    logic                           hit;

    mds_pkg::t_cell_ctl             cell_ctl  [mds_pkg::WIN_DEPTH];
    logic [mds_pkg::BYTE_W-1:0]     view      [mds_pkg::WIN_DEPTH];
    logic [mds_pkg::BYTE_W-1:0]     next_view [mds_pkg::WIN_DEPTH];
    logic [mds_pkg::BYTE_W-1:0]     far_view  [mds_pkg::WIN_DEPTH];
    logic [mds_pkg::WIN_DEPTH-1:0]  match;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= mds_pkg::DELIM_BYTES_RST;
            r_dlen  <= mds_pkg::DELIM_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mds_pkg::REG_DELIM_BYTES:  r_delim <= i_cfg_data;
                mds_pkg::REG_DELIM_LENGTH: r_dlen  <= i_cfg_data[mds_pkg::DLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // length in use: zero acts as one, anything over the maximum as the maximum
    always_comb begin
        if (r_dlen == '0) begin
            len_eff = mds_pkg::WIN_CNT_W'(1);
        end else if (r_dlen > mds_pkg::DLEN_W'(mds_pkg::DELIM_MAX)) begin
            len_eff = mds_pkg::WIN_CNT_W'(mds_pkg::DELIM_MAX);
        end else begin
            len_eff = mds_pkg::WIN_CNT_W'(r_dlen);
        end
    end

    // row of window cells, oldest byte in cell 0
    for (genvar k = 0; k < mds_pkg::WIN_DEPTH; k++) begin : g_cell
        logic [mds_pkg::WIN_CNT_W:0] far_idx;

        assign cell_ctl[k].append = append &&
            (r_count[mds_pkg::WIN_IDX_W-1:0] == mds_pkg::WIN_IDX_W'(k));
        assign cell_ctl[k].active = (mds_pkg::WIN_CNT_W'(k) < len_eff);
        assign cell_ctl[k].shift  = shift;

        if (k + 1 < mds_pkg::WIN_DEPTH) begin : g_nb
            assign next_view[k] = view[k + 1];
        end else begin : g_nb_end
            assign next_view[k] = '0;
        end

        // byte one delimiter length further on, zero past the end
        assign far_idx = (mds_pkg::WIN_CNT_W + 1)'(k) + {1'b0, len_eff};
        always_comb begin
            if (far_idx < (mds_pkg::WIN_CNT_W + 1)'(mds_pkg::WIN_DEPTH)) begin
                far_view[k] = view[far_idx[mds_pkg::WIN_IDX_W-1:0]];
            end else begin
                far_view[k] = '0;
            end
        end

        mds_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl[k]),
            .i_in_byte    (i_in_data.in_byte),
            .i_delim_byte (r_delim[k*mds_pkg::BYTE_W +: mds_pkg::BYTE_W]),
            .i_next_view  (next_view[k]),
            .i_far_view   (far_view[k]),
            .o_view       (view[k]),
            .o_match      (match[k])
        );
    end

    assign hit        = &match;
    assign o_in_stall = (r_state != mds_pkg::ST_RUN) || q_full;
    assign in_take    = i_in_valid && !o_in_stall;
    assign cnt_a      = r_count + mds_pkg::WIN_CNT_W'(1);

    // sequencer: one step per accepted word, then flush and close at end of string
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_open    = r_open;
        append    = 1'b0;
        shift     = mds_pkg::SH_HOLD;
        push      = 1'b0;
        push_word = '0;
        cnt_left  = r_count;
        open_left = r_open;
        unique case (r_state)
            mds_pkg::ST_RUN: begin
                if (in_take) begin
                    append    = 1'b1;
                    cnt_left  = cnt_a;
                    open_left = r_open;
                    if (cnt_a >= len_eff) begin
                        if (hit) begin
                            shift     = mds_pkg::SH_LEN;
                            cnt_left  = cnt_a - len_eff;
                            open_left = 1'b0;
                            if (r_open) begin
                                push                = 1'b1;
                                push_word.token_end = 1'b1;
                            end
                        end else begin
                            shift                = mds_pkg::SH_ONE;
                            cnt_left             = cnt_a - mds_pkg::WIN_CNT_W'(1);
                            open_left            = 1'b1;
                            push                 = 1'b1;
                            push_word.token_byte = view[0];
                        end
                    end
                    n_count = cnt_left;
                    n_open  = open_left;
                    if (i_in_data.end_of_string) begin
                        push_word.run_last = (cnt_left == '0) && !open_left;
                        if (cnt_left != '0) begin
                            n_state = mds_pkg::ST_FLUSH;
                        end else if (open_left) begin
                            n_state = mds_pkg::ST_CLOSE;
                        end
                    end else begin
                        push_word.run_last = 1'b1;
                    end
                end
            end
            mds_pkg::ST_FLUSH: begin
                if (!q_full) begin
                    push                 = 1'b1;
                    push_word.token_byte = view[0];
                    shift                = mds_pkg::SH_ONE;
                    n_count              = r_count - mds_pkg::WIN_CNT_W'(1);
                    n_open               = 1'b1;
                    if (r_count == mds_pkg::WIN_CNT_W'(1)) begin
                        n_state = mds_pkg::ST_CLOSE;
                    end
                end
            end
            mds_pkg::ST_CLOSE: begin
                if (!q_full) begin
                    push                = 1'b1;
                    push_word.token_end = 1'b1;
                    push_word.run_last  = 1'b1;
                    n_open              = 1'b0;
                    n_state             = mds_pkg::ST_RUN;
                end
            end
            default: n_state = mds_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mds_pkg::ST_RUN;
            r_count <= '0;
            r_open  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_open  <= n_open;
        end
    end

    // output queue
    mds_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_word      (push_word),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // window has room for the next byte whenever words are taken
    a_run_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mds_pkg::ST_RUN |->
            r_count < mds_pkg::WIN_CNT_W'(mds_pkg::WIN_DEPTH))
        else $error("window full while taking words");

    // flushing only happens with bytes left
    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mds_pkg::ST_FLUSH |-> r_count != '0)
        else $error("flush with empty window");

    // closing marker only for an open token
    a_close_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mds_pkg::ST_CLOSE |-> r_open)
        else $error("close with no open token");

    // never push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("output queue overflow");

    // a closing marker leaves no token open
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && push_word.token_end |=> !r_open)
        else $error("token still open after end marker");

endmodule

// ----- design/mds_cell.sv -----
// one window cell: holds a pending byte and compares it with its delimiter byte
module mds_cell (
    input  logic                         i_clk,
    input  mds_pkg::t_cell_ctl           i_ctl,
    input  logic [mds_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic [mds_pkg::BYTE_W-1:0]   i_delim_byte,
    input  logic [mds_pkg::BYTE_W-1:0]   i_next_view,
    input  logic [mds_pkg::BYTE_W-1:0]   i_far_view,
    output logic [mds_pkg::BYTE_W-1:0]   o_view,
    output logic                         o_match
);

    logic [mds_pkg::BYTE_W-1:0] r_byte;
    logic [mds_pkg::BYTE_W-1:0] n_byte;

    // contents as seen once this cycle's byte is appended
    assign o_view  = i_ctl.append ? i_in_byte : r_byte;

    // cells beyond the delimiter length always agree
    assign o_match = !i_ctl.active || (o_view == i_delim_byte);

    // take from self, the neighbour, or the cell a delimiter length on
    always_comb begin
        case (i_ctl.shift)
            mds_pkg::SH_ONE: n_byte = i_next_view;
            mds_pkg::SH_LEN: n_byte = i_far_view;
            default:         n_byte = o_view;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

// ----- design/mds_outq.sv -----
// two-word output queue decoupling the splitter core from downstream stall
module mds_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mds_pkg::t_out_word i_word,
    output logic               o_full,
    output logic               o_out_valid,
    output mds_pkg::t_out_word o_out_data,
    input  logic               i_out_stall
);

    mds_pkg::t_out_word                r_mem [mds_pkg::OQ_DEPTH];
    logic [mds_pkg::OQ_PTR_W-1:0]      r_wptr;
    logic [mds_pkg::OQ_PTR_W-1:0]      r_rptr;
    logic [mds_pkg::OQ_CNT_W-1:0]      r_count;
    logic [mds_pkg::OQ_PTR_W-1:0]      n_wptr;
    logic [mds_pkg::OQ_PTR_W-1:0]      n_rptr;
    logic [mds_pkg::OQ_CNT_W-1:0]      n_count;
    logic                              pop;

    assign o_full      = (r_count == mds_pkg::OQ_CNT_W'(mds_pkg::OQ_DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rptr];
    assign pop         = o_out_valid && !i_out_stall;

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == mds_pkg::OQ_PTR_W'(mds_pkg::OQ_DEPTH - 1)) ?
                     '0 : r_wptr + mds_pkg::OQ_PTR_W'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == mds_pkg::OQ_PTR_W'(mds_pkg::OQ_DEPTH - 1)) ?
                     '0 : r_rptr + mds_pkg::OQ_PTR_W'(1);
        end
        if (i_push && !pop) begin
            n_count = r_count + mds_pkg::OQ_CNT_W'(1);
        end else if (pop && !i_push) begin
            n_count = r_count - mds_pkg::OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the multibyte delimiter splitter core
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 200000;

    // token tracker: own copy of window, token state and registers
    class split_tracker;
        logic [mds_pkg::DELIM_W-1:0] delim;
        logic [mds_pkg::DLEN_W-1:0]  dlen;
        logic [mds_pkg::BYTE_W-1:0]  win [mds_pkg::WIN_DEPTH];
        int                          win_cnt;
        bit                          open_token;
        mds_pkg::t_out_word          expected_tokens [$];
        int                          errors;

        function new();
            delim      = mds_pkg::DELIM_BYTES_RST;
            dlen       = mds_pkg::DELIM_LENGTH_RST;
            foreach (win[k]) win[k] = '0;
            win_cnt    = 0;
            open_token = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [mds_pkg::CFG_IDX_W-1:0] idx,
                                logic [mds_pkg::DELIM_W-1:0] data);
            if (idx == mds_pkg::REG_DELIM_BYTES) begin
                delim = data;
            end else if (idx == mds_pkg::REG_DELIM_LENGTH) begin
                dlen = data[mds_pkg::DLEN_W-1:0];
            end
        endfunction

        // zero counts as one, anything above the window as full width
        function int eff_len();
            int n;
            n = int'(dlen);
            if (n == 0) n = 1;
            if (n > mds_pkg::DELIM_MAX) n = mds_pkg::DELIM_MAX;
            return n;
        endfunction

        function void drop_front(int n);
            if (n > win_cnt) n = win_cnt;
            for (int k = 0; k < mds_pkg::WIN_DEPTH; k++) begin
                win[k] = (k + n < mds_pkg::WIN_DEPTH) ? win[k + n] : '0;
            end
            win_cnt -= n;
        endfunction

        function void emit(logic [mds_pkg::BYTE_W-1:0] b, logic is_end);
            mds_pkg::t_out_word r;
            r.token_byte = b;
            r.token_end  = is_end;
            r.run_last   = 1'b0;
            expected_tokens.insert(expected_tokens.size(), r);
        endfunction

        // predict the words one accepted byte gives
        function void take_byte(mds_pkg::t_in_word w);
            int len;
            int first;
            bit hit;
            len   = eff_len();
            first = expected_tokens.size();
            if (win_cnt >= mds_pkg::WIN_DEPTH) drop_front(1);
            win[win_cnt] = w.in_byte;
            win_cnt++;
            if (win_cnt >= len) begin
                hit = 1'b1;
                for (int k = 0; k < len; k++) begin
                    if (win[k] != delim[mds_pkg::BYTE_W*k +: mds_pkg::BYTE_W]) hit = 1'b0;
                end
                if (hit) begin
                    drop_front(len);
                    if (open_token) begin
                        emit('0, 1'b1);
                        open_token = 1'b0;
                    end
                end else begin
                    emit(win[0], 1'b0);
                    open_token = 1'b1;
                    drop_front(1);
                end
            end
            // end of string: flush the window and close the token
            if (w.end_of_string) begin
                while (win_cnt > 0) begin
                    emit(win[0], 1'b0);
                    open_token = 1'b1;
                    drop_front(1);
                end
                if (open_token) begin
                    emit('0, 1'b1);
                    open_token = 1'b0;
                end
            end
            if (expected_tokens.size() > first) begin
                expected_tokens[expected_tokens.size()-1].run_last = 1'b1;
            end
        endfunction

        // compare one output word with the oldest prediction
        function void match_token(mds_pkg::t_out_word got);
            mds_pkg::t_out_word want;
            if (expected_tokens.size() == 0) begin
                $error("unexpected word: token_byte %0h token_end %0b run_last %0b",
                       got.token_byte, got.token_end, got.run_last);
                errors++;
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_byte !== want.token_byte) begin
                $error("token_byte: expected %0h, got %0h", want.token_byte, got.token_byte);
                errors++;
            end
            if (got.token_end !== want.token_end) begin
                $error("token_end: expected %0b, got %0b", want.token_end, got.token_end);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    mds_pkg::t_in_word             i_in_data   = '0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    mds_pkg::t_out_word            o_out_data;
    logic                          i_out_stall = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [mds_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [mds_pkg::DELIM_W-1:0]   i_cfg_data  = '0;

    bit                in_idle_on  = 1'b1;
    bit                out_idle_on = 1'b1;
    int unsigned       cycle_count = 0;
    split_tracker      sb          = new();
    mds_pkg::t_in_word plan_q [$];

    multibyte_delimiter_splitter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // monitor: check the output word first, then note the accepted input word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.match_token(o_out_data);
            if (i_in_valid && !o_in_stall) sb.take_byte(i_in_data);
        end
    end

    // receiver back-pressure in short bursts
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && out_idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 4);
                i_out_stall <= 1'b1;
                repeat (burst) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
        end
    end

    // offer one word, with an occasional gap first, and wait for acceptance
    task automatic push_word(input logic [mds_pkg::BYTE_W-1:0] b, input logic eos);
        int                gap;
        mds_pkg::t_in_word w;
        w.in_byte       = b;
        w.end_of_string = eos;
        gap = (in_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait until every predicted word is out
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mds_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mds_pkg::DELIM_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // build one string: tokens, whole and partial delimiters, or plain noise
    function automatic void plan_string();
        int                len;
        int                cut;
        mds_pkg::t_in_word w;
        len             = sb.eff_len();
        w.end_of_string = 1'b0;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 10)) begin
                w.in_byte = mds_pkg::BYTE_W'($urandom_range(0, 255));
                plan_q.insert(plan_q.size(), w);
            end
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        repeat ($urandom_range(1, 4)) begin
                            w.in_byte = mds_pkg::BYTE_W'($urandom_range(0, 255));
                            plan_q.insert(plan_q.size(), w);
                        end
                    end
                    2, 3: begin
                        for (int k = 0; k < len; k++) begin
                            w.in_byte = sb.delim[mds_pkg::BYTE_W*k +: mds_pkg::BYTE_W];
                            plan_q.insert(plan_q.size(), w);
                        end
                    end
                    4: begin
                        // delimiter prefix broken by a stray byte
                        cut = $urandom_range(0, len - 1);
                        for (int k = 0; k < cut; k++) begin
                            w.in_byte = sb.delim[mds_pkg::BYTE_W*k +: mds_pkg::BYTE_W];
                            plan_q.insert(plan_q.size(), w);
                        end
                        w.in_byte = mds_pkg::BYTE_W'($urandom_range(0, 255));
                        plan_q.insert(plan_q.size(), w);
                    end
                    default: begin
                        w.in_byte = mds_pkg::BYTE_W'($urandom_range(0, 255));
                        plan_q.insert(plan_q.size(), w);
                    end
                endcase
            end
        end
        plan_q[plan_q.size()-1].end_of_string = 1'b1;
    endfunction

    // stimulus
    initial begin
        int                          lens [8];
        logic [mds_pkg::DELIM_W-1:0] pattern;
        logic [mds_pkg::DELIM_W-1:0] len_data;
        mds_pkg::t_in_word           w;

        lens = '{1, 8, 2, 0, 15, 3, 5, 8};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset delimiter ',': plain split, lone delimiter, one-byte token, byte extremes
        push_word(8'h61, 1'b0);
        push_word(8'h2c, 1'b0);
        push_word(8'h62, 1'b1);
        push_word(8'h2c, 1'b1);
        push_word(8'h7a, 1'b1);
        push_word(8'hff, 1'b0);
        push_word(8'h00, 1'b1);
        settle();

        // length zero behaves as one, delimiter NUL, two delimiters in a row
        write_reg(mds_pkg::REG_DELIM_BYTES, '0);
        write_reg(mds_pkg::REG_DELIM_LENGTH, '0);
        push_word(8'h41, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'h42, 1'b1);
        settle();

        // length fifteen clamps to eight
        pattern = {$urandom, $urandom};
        write_reg(mds_pkg::REG_DELIM_BYTES, pattern);
        write_reg(mds_pkg::REG_DELIM_LENGTH, mds_pkg::DELIM_W'(15));
        push_word(8'h11, 1'b0);
        for (int k = 0; k < mds_pkg::DELIM_MAX; k++) begin
            push_word(pattern[mds_pkg::BYTE_W*k +: mds_pkg::BYTE_W],
                      k == mds_pkg::DELIM_MAX - 1);
        end
        settle();

        // delimiter shortened and changed while the window still holds bytes
        write_reg(mds_pkg::REG_DELIM_BYTES, mds_pkg::DELIM_W'(64'h4443_4241));
        write_reg(mds_pkg::REG_DELIM_LENGTH, mds_pkg::DELIM_W'(4));
        push_word(8'h78, 1'b0);
        push_word(8'h41, 1'b0);
        push_word(8'h42, 1'b0);
        settle();
        write_reg(mds_pkg::REG_DELIM_BYTES, mds_pkg::DELIM_W'(64'h4178));
        write_reg(mds_pkg::REG_DELIM_LENGTH, mds_pkg::DELIM_W'(2));
        push_word(8'h43, 1'b1);
        settle();

        // random strings under a run of settings; unfinished strings carry over
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0:       pattern = '1;
                1:       pattern = '0;
                default: pattern = {$urandom, $urandom};
            endcase
            len_data         = {$urandom, $urandom};
            len_data[3:0]    = lens[p][3:0];
            in_idle_on       = (p != 2 && p != 7);
            out_idle_on      = (p != 2 && p != 7);
            if ($urandom_range(0, 1) == 0) begin
                write_reg(mds_pkg::REG_DELIM_BYTES, pattern);
                write_reg(mds_pkg::REG_DELIM_LENGTH, len_data);
            end else begin
                write_reg(mds_pkg::REG_DELIM_LENGTH, len_data);
                write_reg(mds_pkg::REG_DELIM_BYTES, pattern);
            end
            for (int n = 0; n < 23; n++) begin
                if (plan_q.size() == 0) plan_string();
                w = plan_q.pop_front();
                push_word(w.in_byte, w.end_of_string);
            end
            settle();
        end

        if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ----- multibyte_delimiter_splitter_core.f -----
design/mds_pkg.sv
design/mds_cell.sv
design/mds_outq.sv
design/multibyte_delimiter_splitter_core.sv
bench/tb_top.sv
